### sv/sliding_median_adc_filter_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sliding median filter checker
// Each macro clocks on clk_i and is disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SLIDING_MEDIAN_ADC_FILTER_CORE_DEFINES_SVH
`define SLIDING_MEDIAN_ADC_FILTER_CORE_DEFINES_SVH

// Same-cycle implication.
`define SMAF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("smaf checker: property failed");

// Next-cycle implication.
`define SMAF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("smaf checker: property failed");

`endif

### sv/smaf_pkg.sv
// ----------------------------------------------------------------------------
// smaf_pkg
// Shared types and constants of the sliding median filter.
// ----------------------------------------------------------------------------
package smaf_pkg;

  // Result field widths
  localparam int unsigned MEDIAN_W = 10;
  localparam int unsigned VOLT_W   = 23;

  // Millivolt full scale, result is in 1/1024 mV
  localparam int unsigned          MV_W          = 13;
  localparam logic [MV_W-1:0]      MV_FULL_SCALE = 13'd5000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEL,
    ST_INS,
    ST_MED,
    ST_OUT
  } smaf_state_e;

  typedef struct packed {
    logic busy;      // request side stalled
    logic take;      // latch incoming sample
    logic del_en;    // remove oldest sample from sorted chain
    logic ins_en;    // insert new sample into sorted chain
    logic med_en;    // register median of middle pair
    logic out_load;  // load result register
  } smaf_ctrl_t;

endpackage

### sv/sliding_median_adc_filter_core.sv
// ----------------------------------------------------------------------------
// sliding_median_adc_filter_core
// Running median of the last WINDOW converter samples, with millivolt scaling.
// ----------------------------------------------------------------------------
// A request is taken only while idle, and the next one waits until it is done:
// accept, then drop the oldest sample from the sorted cell chain, insert the
// new one, add the two middle cells, and multiply into the result register.
// The result load waits while the previous result is still stalled. The window
// starts as WINDOW zeros, which count toward the median until replaced. No
// clearing pass is needed.
module sliding_median_adc_filter_core #(
  parameter int unsigned WINDOW      = 30,
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [SAMPLE_BITS-1:0]         sample_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [smaf_pkg::MEDIAN_W-1:0]  median_code_o,
  output logic [smaf_pkg::VOLT_W-1:0]    voltage_scaled_o
);

  import smaf_pkg::*;

  localparam int unsigned HI_RANK = WINDOW / 2;
  localparam int unsigned LO_RANK = (WINDOW % 2 == 0) ? WINDOW / 2 - 1 : WINDOW / 2;
  localparam int unsigned PROD_W  = SAMPLE_BITS + MV_W;

  smaf_ctrl_t ctrl;
  logic       slot_free;

  logic [SAMPLE_BITS-1:0] sample_q;
  logic [SAMPLE_BITS-1:0] age_q [WINDOW];
  logic [SAMPLE_BITS-1:0] old_val;

  logic [SAMPLE_BITS-1:0] cell_val  [WINDOW];
  logic                   cell_gt   [WINDOW];
  logic [SAMPLE_BITS-1:0] left_val  [WINDOW];
  logic                   left_gt   [WINDOW];
  logic [SAMPLE_BITS-1:0] right_val [WINDOW];
  logic                   self_top  [WINDOW];

  logic [SAMPLE_BITS:0]   mid_sum;
  logic [SAMPLE_BITS-1:0] med_q;
  logic [PROD_W-1:0]      prod;

  logic                   out_valid_q;
  logic [MEDIAN_W-1:0]    median_q;
  logic [VOLT_W-1:0]      volt_q;

  assign slot_free  = ~out_valid_q | ~out_stall_i;
  assign in_stall_o = ctrl.busy;

  smaf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .slot_free_i (slot_free),
    .ctrl_o      (ctrl)
  );

  always_ff @(posedge clk_i) begin
    if (ctrl.take) begin
      sample_q <= sample_i;
    end
  end

  // arrival-order line: oldest sample falls out of the last tap
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < WINDOW; k++) begin
        age_q[k] <= '0;
      end
    end else if (ctrl.del_en) begin
      age_q[0] <= sample_q;
      for (int k = 1; k < WINDOW; k++) begin
        age_q[k] <= age_q[k-1];
      end
    end
  end

  assign old_val = age_q[WINDOW-1];

  for (genvar k = 0; k < WINDOW; k++) begin : g_cell
    if (k == 0) begin : g_first
      assign left_val[k] = '0;
      assign left_gt[k]  = 1'b0;
    end else begin : g_mid_l
      assign left_val[k] = cell_val[k-1];
      assign left_gt[k]  = cell_gt[k-1];
    end
    if (k == WINDOW - 1) begin : g_last
      assign right_val[k] = sample_q;
      assign self_top[k]  = 1'b1;
    end else begin : g_mid_r
      assign right_val[k] = cell_val[k+1];
      assign self_top[k]  = 1'b0;
    end

    smaf_sort_cell #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .del_en_i    (ctrl.del_en),
      .ins_en_i    (ctrl.ins_en),
      .old_i       (old_val),
      .new_i       (sample_q),
      .left_val_i  (left_val[k]),
      .left_gt_i   (left_gt[k]),
      .right_val_i (right_val[k]),
      .self_top_i  (self_top[k]),
      .val_o       (cell_val[k]),
      .gt_o        (cell_gt[k])
    );
  end

  // floor of the middle-pair mean; odd windows use the same cell twice
  assign mid_sum = {1'b0, cell_val[LO_RANK]} + {1'b0, cell_val[HI_RANK]};

  always_ff @(posedge clk_i) begin
    if (ctrl.med_en) begin
      med_q <= mid_sum[SAMPLE_BITS:1];
    end
  end

  assign prod = PROD_W'(med_q) * PROD_W'(MV_FULL_SCALE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_load) begin
      median_q <= MEDIAN_W'(med_q);
      volt_q   <= VOLT_W'(prod);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign median_code_o    = median_q;
  assign voltage_scaled_o = volt_q;

endmodule

### sv/smaf_sort_cell.sv
// ----------------------------------------------------------------------------
// smaf_sort_cell
// One position of the sorted sample chain. Deletes by shifting down from the
// right neighbor, inserts by shifting up from the left neighbor.
// ----------------------------------------------------------------------------
module smaf_sort_cell #(
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   del_en_i,
  input  logic                   ins_en_i,
  input  logic [SAMPLE_BITS-1:0] old_i,
  input  logic [SAMPLE_BITS-1:0] new_i,
  input  logic [SAMPLE_BITS-1:0] left_val_i,
  input  logic                   left_gt_i,
  input  logic [SAMPLE_BITS-1:0] right_val_i,
  input  logic                   self_top_i,
  output logic [SAMPLE_BITS-1:0] val_o,
  output logic                   gt_o
);

  logic [SAMPLE_BITS-1:0] val_q, val_d;
  logic                   own_gt;

  assign gt_o   = (val_q > new_i);
  // top cell holds a vacated slot after delete and acts as +infinity
  assign own_gt = self_top_i | gt_o;
  assign val_o  = val_q;

  always_comb begin
    val_d = val_q;
    if (del_en_i) begin
      // sorted order: every cell at or above the first match of old shifts down
      if (val_q >= old_i) begin
        val_d = right_val_i;
      end
    end else if (ins_en_i) begin
      priority if (left_gt_i) begin
        val_d = left_val_i;
      end else if (own_gt) begin
        val_d = new_i;
      end else begin
        // below the insertion point: keep
        val_d = val_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
    end else begin
      val_q <= val_d;
    end
  end

endmodule

### sv/smaf_ctrl.sv
// ----------------------------------------------------------------------------
// smaf_ctrl
// Sequencer: accept, delete oldest, insert newest, median, result load.
// ----------------------------------------------------------------------------
module smaf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                slot_free_i,
  output smaf_pkg::smaf_ctrl_t ctrl_o
);

  import smaf_pkg::*;

  smaf_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_DEL;
      ST_DEL:  state_d = ST_INS;
      ST_INS:  state_d = ST_MED;
      ST_MED:  state_d = ST_OUT;
      ST_OUT:  if (slot_free_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o          = '0;
    ctrl_o.busy     = (state_q != ST_IDLE);
    ctrl_o.take     = (state_q == ST_IDLE) & in_valid_i;
    ctrl_o.del_en   = (state_q == ST_DEL);
    ctrl_o.ins_en   = (state_q == ST_INS);
    ctrl_o.med_en   = (state_q == ST_MED);
    ctrl_o.out_load = (state_q == ST_OUT) & slot_free_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### sv/smaf_checker.sv
// ----------------------------------------------------------------------------
// smaf_checker
// Port-level checks of the sliding median filter, bound to the top level.
// ----------------------------------------------------------------------------
`include "sliding_median_adc_filter_core_defines.svh"

module smaf_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [smaf_pkg::MEDIAN_W-1:0] median_code_o,
  input logic [smaf_pkg::VOLT_W-1:0]   voltage_scaled_o
);

  // an accepted request keeps the block busy through the delete and insert steps
  `SMAF_ASSERT_NXT(a_busy_after_req, in_valid_i && !in_stall_o, in_stall_o ##1 in_stall_o)

  // a new result only appears from the busy sequence
  `SMAF_ASSERT_IMP(a_result_from_busy, $rose(out_valid_o), $past(in_stall_o))

  // stalled result holds
  `SMAF_ASSERT_NXT(a_result_hold, out_valid_o && out_stall_i,
                   out_valid_o && $stable(median_code_o) && $stable(voltage_scaled_o))

  // the scale factor is a multiple of eight
  `SMAF_ASSERT_IMP(a_volt_align, out_valid_o, voltage_scaled_o[2:0] == 3'd0)

endmodule

bind sliding_median_adc_filter_core smaf_checker u_smaf_checker (.*);
